>>> src/auto_ranging_histogram_assert.svh
// Assertion macros for the auto-ranging histogram RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef AUTO_RANGING_HISTOGRAM_ASSERT_SVH
`define AUTO_RANGING_HISTOGRAM_ASSERT_SVH

// check a condition at every clock edge outside reset
`define ARH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// check that a condition in one cycle implies another in the next
`define ARH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/arh_pkg.sv
// Shared types and constants of the auto-ranging histogram.
// No dependencies.
`default_nettype none

package arh_pkg;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 32;
    localparam int OVF_W  = 48;
    localparam int LE_W   = 34;
    localparam int DIV_W  = 36;
    localparam int BW_W   = 31;
    localparam int MAXB_W = 11;
    localparam int SEL_W  = 10;
    localparam int WT_W   = 16;
    localparam int CMP_W  = 38;

    localparam logic [1:0] ST_BIN  = 2'd0;
    localparam logic [1:0] ST_OOR  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_RDX  = 2'd3;

    localparam logic [1:0] CFG_BEGIN = 2'd0;
    localparam logic [1:0] CFG_WIDTH = 2'd1;
    localparam logic [1:0] CFG_MAXB  = 2'd2;

    localparam logic [BW_W-1:0]   BW_RESET   = 31'd65536;
    localparam logic [MAXB_W-1:0] MAXB_RESET = 11'd1024;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_DIV,
        S_PLAN,
        S_GROW,
        S_RDA,
        S_RDD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic plan;
        logic grow_step;
        logic rd_issue;
        logic rd_done;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic in_range;
        logic div_done;
        logic left_zero;
        logic counted;
    } t_sts;

endpackage

`default_nettype wire

>>> src/arh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> src/arh_ctrl.sv
// Sequencer of the auto-ranging histogram: divide, plan, grow, update, and bin reads.
// Depends on arh_pkg.
`default_nettype none

module arh_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output arh_pkg::t_cmd    o_cmd,
    input  arh_pkg::t_sts    i_sts
);

    arh_pkg::t_state r_state;
    arh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            arh_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = arh_pkg::S_DISP;
                end
            end
            arh_pkg::S_DISP: begin
                if (!i_sts.is_read) begin
                    n_state = arh_pkg::S_DIV;
                end else if (i_sts.in_range) begin
                    n_state = arh_pkg::S_RDA;
                end else begin
                    n_state = arh_pkg::S_DONE;
                end
            end
            arh_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = arh_pkg::S_PLAN;
                end
            end
            arh_pkg::S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = arh_pkg::S_GROW;
            end
            arh_pkg::S_GROW: begin
                if (!i_sts.left_zero) begin
                    o_cmd.grow_step = 1'b1;
                end else if (i_sts.counted) begin
                    n_state = arh_pkg::S_RDA;
                end else begin
                    n_state = arh_pkg::S_DONE;
                end
            end
            arh_pkg::S_RDA: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = arh_pkg::S_RDD;
            end
            arh_pkg::S_RDD: begin
                o_cmd.rd_done = 1'b1;
                n_state       = arh_pkg::S_DONE;
            end
            arh_pkg::S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = arh_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arh_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/arh_dp.sv
// Datapath of the auto-ranging histogram: config, range state, divider, bin RAM.
// Depends on arh_pkg, arh_ram and auto_ranging_histogram_assert.svh.
`default_nettype none

`include "auto_ranging_histogram_assert.svh"

module arh_dp #(
    parameter int MAX_BINS = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [1:0]                          i_cfg_index,
    input  wire [31:0]                         i_cfg_data,
    input  arh_pkg::t_cmd                      i_cmd,
    output arh_pkg::t_sts                      o_sts,
    input  wire                                i_func,
    input  wire signed [arh_pkg::VAL_W-1:0]    i_value,
    input  wire [arh_pkg::WT_W-1:0]            i_weight,
    input  wire [arh_pkg::SEL_W-1:0]           i_bin_select,
    output logic [1:0]                         o_status,
    output logic [arh_pkg::SEL_W-1:0]          o_bin_index,
    output logic [arh_pkg::CNT_W-1:0]          o_bin_count,
    output logic signed [32:0]                 o_range_start,
    output logic [arh_pkg::MAXB_W-1:0]         o_used_bins,
    output logic [arh_pkg::OVF_W-1:0]          o_out_of_range_sum,
    output logic                               o_limit_hit
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int PW = $clog2(MAX_BINS + 1);
    localparam int DCW = $clog2(arh_pkg::DIV_W);

    logic signed [31:0]                 r_ibeg, n_ibeg;
    logic [arh_pkg::BW_W-1:0]           r_bw, n_bw;
    logic [arh_pkg::MAXB_W-1:0]         r_maxb, n_maxb;
    logic signed [arh_pkg::LE_W-1:0]    r_lower, n_lower;
    logic [IW-1:0]                      r_base, n_base;
    logic [PW-1:0]                      r_bins, n_bins;
    logic                               r_ref, n_ref;
    logic [arh_pkg::OVF_W-1:0]          r_ovf, n_ovf;

    logic                               r_func, n_func;
    logic signed [arh_pkg::VAL_W-1:0]   r_val, n_val;
    logic [arh_pkg::WT_W-1:0]           r_wt, n_wt;
    logic [arh_pkg::SEL_W-1:0]          r_sel, n_sel;
    logic [IW-1:0]                      r_bin, n_bin;
    logic                               r_neg, n_neg;
    logic [arh_pkg::DIV_W-1:0]          r_quo, n_quo;
    logic [arh_pkg::BW_W-1:0]           r_rem, n_rem;
    logic [DCW-1:0]                     r_dcnt, n_dcnt;
    logic [PW-1:0]                      r_left, n_left;
    logic                               r_pre, n_pre;
    logic                               r_ok, n_ok;

    logic [1:0]                         r_status, n_status;
    logic [arh_pkg::SEL_W-1:0]          r_idx, n_idx;
    logic [arh_pkg::CNT_W-1:0]          r_cnt, n_cnt;

    logic                               ram_we;
    logic [IW-1:0]                      ram_waddr;
    logic [IW-1:0]                      ram_raddr;
    logic [arh_pkg::CNT_W-1:0]          ram_wdata;
    logic [arh_pkg::CNT_W-1:0]          ram_rdata;

    logic [arh_pkg::BW_W-1:0]           w_eff;
    logic [31:0]                        lim32;
    logic [31:0]                        room32;
    logic [31:0]                        bins32;
    logic signed [arh_pkg::DIV_W-1:0]   d_diff;
    logic [31:0]                        trial;
    logic                               rem_zero;
    logic [arh_pkg::BW_W-1:0]           rem_floor;
    logic [arh_pkg::CMP_W-1:0]          need;
    logic [arh_pkg::CMP_W-1:0]          binv;
    logic [arh_pkg::CMP_W-1:0]          room38;
    logic [arh_pkg::CMP_W-1:0]          bins38;
    logic                               refused;
    logic                               do_app;
    logic [IW-1:0]                      base_dec;
    logic [32:0]                        cnt_sum;
    logic [arh_pkg::OVF_W:0]            ovf_sum;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base, input logic [IW-1:0] pos);
        logic [IW:0] s;
        s = {1'b0, base} + {1'b0, pos};
        if (s >= (IW + 1)'(MAX_BINS)) begin
            s = s - (IW + 1)'(MAX_BINS);
        end
        return s[IW-1:0];
    endfunction

    arh_ram #(
        .WIDTH (arh_pkg::CNT_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        w_eff = (r_bw == '0) ? arh_pkg::BW_W'(1) : r_bw;
        if (r_maxb == '0) begin
            lim32 = 32'd1;
        end else if (32'(r_maxb) > 32'(MAX_BINS)) begin
            lim32 = 32'(MAX_BINS);
        end else begin
            lim32 = 32'(r_maxb);
        end
        bins32   = 32'(r_bins);
        room32   = (lim32 > bins32) ? lim32 - bins32 : 32'd0;
        room38   = arh_pkg::CMP_W'(room32);
        bins38   = arh_pkg::CMP_W'(bins32);
        d_diff   = arh_pkg::DIV_W'(i_value) - arh_pkg::DIV_W'(r_lower);
        trial    = {r_rem, r_quo[arh_pkg::DIV_W-1]};
        rem_zero = (r_rem == '0);
        rem_floor = (r_neg && !rem_zero) ? w_eff - r_rem : r_rem;
        need     = arh_pkg::CMP_W'(r_quo) + (rem_zero ? arh_pkg::CMP_W'(0) : arh_pkg::CMP_W'(1));
        base_dec = (r_base == '0) ? IW'(MAX_BINS - 1) : r_base - IW'(1);
        cnt_sum  = {1'b0, ram_rdata} + 33'(r_wt);
        ovf_sum  = {1'b0, r_ovf} + (arh_pkg::OVF_W + 1)'(r_wt);
        binv     = '0;
        refused  = 1'b0;
        do_app   = 1'b0;

        n_ibeg = r_ibeg;   n_bw = r_bw;     n_maxb = r_maxb;
        n_lower = r_lower; n_base = r_base; n_bins = r_bins;
        n_ref = r_ref;     n_ovf = r_ovf;
        n_func = r_func;   n_val = r_val;   n_wt = r_wt;     n_sel = r_sel;
        n_bin = r_bin;     n_neg = r_neg;   n_quo = r_quo;   n_rem = r_rem;
        n_dcnt = r_dcnt;   n_left = r_left; n_pre = r_pre;   n_ok = r_ok;
        n_status = r_status; n_idx = r_idx; n_cnt = r_cnt;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = slot(r_base, r_bin);

        if (i_cfg_we) begin
            case (i_cfg_index)
                arh_pkg::CFG_BEGIN: begin
                    n_ibeg = $signed(i_cfg_data);
                    if (r_bins == '0) begin
                        n_lower = arh_pkg::LE_W'($signed(i_cfg_data));
                    end
                end
                arh_pkg::CFG_WIDTH: n_bw = i_cfg_data[arh_pkg::BW_W-1:0];
                arh_pkg::CFG_MAXB:  n_maxb = i_cfg_data[arh_pkg::MAXB_W-1:0];
                default: ;
            endcase
        end

        if (i_cmd.load) begin
            n_func  = i_func;
            n_val   = i_value;
            n_wt    = i_weight;
            n_sel   = i_bin_select;
            n_bin   = IW'(i_bin_select);
            n_idx   = i_func ? i_bin_select : '0;
            n_cnt   = '0;
            n_status = i_func ? arh_pkg::ST_RDX : arh_pkg::ST_OOR;
            n_neg   = d_diff[arh_pkg::DIV_W-1];
            n_quo   = d_diff[arh_pkg::DIV_W-1] ? arh_pkg::DIV_W'(-d_diff)
                                               : arh_pkg::DIV_W'(d_diff);
            n_rem   = '0;
            n_dcnt  = DCW'(arh_pkg::DIV_W - 1);
            n_left  = '0;
            n_pre   = 1'b0;
            n_ok    = 1'b0;
        end

        if (i_cmd.div_step) begin
            if (trial >= 32'(w_eff)) begin
                n_rem = arh_pkg::BW_W'(trial - 32'(w_eff));
                n_quo = {r_quo[arh_pkg::DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[arh_pkg::BW_W-1:0];
                n_quo = {r_quo[arh_pkg::DIV_W-2:0], 1'b0};
            end
            n_dcnt = r_dcnt - DCW'(1);
        end

        if (i_cmd.plan) begin
            if (r_bins == '0) begin
                n_lower = arh_pkg::LE_W'(r_val) - arh_pkg::LE_W'(rem_floor);
                binv    = '0;
                do_app  = 1'b1;
            end else if (r_neg) begin
                n_pre = 1'b1;
                if (need > room38) begin
                    n_left  = PW'(room32);
                    refused = 1'b1;
                end else begin
                    n_left = PW'(need);
                end
            end else begin
                binv   = arh_pkg::CMP_W'(r_quo);
                do_app = 1'b1;
            end
            if (do_app && binv >= bins38) begin
                if (binv + arh_pkg::CMP_W'(1) > bins38 + room38) begin
                    n_left  = PW'(room32);
                    refused = 1'b1;
                end else begin
                    n_left = PW'(binv + arh_pkg::CMP_W'(1) - bins38);
                end
            end
            n_bin = IW'(binv);
            n_ok  = !refused;
            if (refused) begin
                n_ref = 1'b1;
                n_ovf = ovf_sum[arh_pkg::OVF_W] ? '1 : ovf_sum[arh_pkg::OVF_W-1:0];
            end
        end

        if (i_cmd.grow_step) begin
            ram_we = 1'b1;
            if (r_pre) begin
                n_base    = base_dec;
                ram_waddr = base_dec;
                n_lower   = r_lower - arh_pkg::LE_W'(w_eff);
            end else begin
                ram_waddr = slot(r_base, IW'(r_bins));
            end
            n_bins = r_bins + PW'(1);
            n_left = r_left - PW'(1);
        end

        if (i_cmd.rd_done) begin
            n_idx = r_func ? r_sel : arh_pkg::SEL_W'(r_bin);
            if (r_func) begin
                n_status = arh_pkg::ST_RD;
                n_cnt    = ram_rdata;
            end else begin
                n_status  = arh_pkg::ST_BIN;
                n_cnt     = cnt_sum[32] ? '1 : cnt_sum[31:0];
                ram_we    = 1'b1;
                ram_waddr = slot(r_base, r_bin);
                ram_wdata = n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ibeg  <= '0;
            r_bw    <= arh_pkg::BW_RESET;
            r_maxb  <= arh_pkg::MAXB_RESET;
            r_lower <= '0;
            r_base  <= '0;
            r_bins  <= '0;
            r_ref   <= 1'b0;
            r_ovf   <= '0;
        end else begin
            r_ibeg  <= n_ibeg;
            r_bw    <= n_bw;
            r_maxb  <= n_maxb;
            r_lower <= n_lower;
            r_base  <= n_base;
            r_bins  <= n_bins;
            r_ref   <= n_ref;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_val    <= n_val;
        r_wt     <= n_wt;
        r_sel    <= n_sel;
        r_bin    <= n_bin;
        r_neg    <= n_neg;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_dcnt   <= n_dcnt;
        r_left   <= n_left;
        r_pre    <= n_pre;
        r_ok     <= n_ok;
        r_status <= n_status;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
    end

    assign o_sts.is_read   = r_func;
    assign o_sts.in_range  = 32'(r_sel) < bins32;
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.left_zero = (r_left == '0);
    assign o_sts.counted   = r_ok;

    assign o_status           = r_status;
    assign o_bin_index        = r_idx;
    assign o_bin_count        = r_cnt;
    assign o_range_start      = 33'(r_lower);
    assign o_used_bins        = arh_pkg::MAXB_W'(r_bins);
    assign o_out_of_range_sum = r_ovf;
    assign o_limit_hit        = r_ref;

    `ARH_ASSERT_ALWAYS(a_bins_bound, 32'(r_bins) <= 32'(MAX_BINS), "bins in use past capacity")
    `ARH_ASSERT_ALWAYS(a_base_bound, 32'(r_base) < 32'(MAX_BINS), "ring base out of range")
    `ARH_ASSERT_NEXT(a_ref_sticky, r_ref, r_ref, "limit flag cleared without reset")
    `ARH_ASSERT_NEXT(a_ovf_mono, 1'b1, r_ovf >= $past(r_ovf), "out-of-range total decreased")
    `ARH_ASSERT_NEXT(a_rd_done, i_cmd.rd_issue, i_cmd.rd_done, "bin read not completed")

endmodule

`default_nettype wire

>>> src/auto_ranging_histogram.sv
// Top level of the auto-ranging histogram: sequencer plus datapath.
// Depends on arh_pkg, arh_ctrl, arh_dp (and arh_ram through it).
//
//   channel  direction  handshake                    payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tdata value,weight,bin_select; tuser func
//   m_axis   out        m_axis_tvalid/m_axis_tready  tdata result fields; tuser status
//   cfg      in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// Insert: accept, dispatch, a divider step per quotient bit, plan, a grow step per added bin and
//   a final grow check, bin read and update, then the result; read and update are skipped when refused.
// Read: accept, dispatch, bin read, then the result; a bin past the used range skips the bin read.
// One request at a time; the result register holds until m_axis_tready.
// Reset is synchronous; the bin RAM needs no clearing, new bins are zeroed as added.
`default_nettype none

module auto_ranging_histogram #(
    parameter int MAX_BINS = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [1:0]    i_cfg_index,
    input  wire [31:0]   i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [63:0]   s_axis_tdata,   // value[31:0], weight[47:32], bin_select[57:48], zero
    input  wire          s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [135:0] m_axis_tdata,   // bin_index, bin_count, range_start, used_bins,
                                         // out_of_range_sum, limit_hit, zero
    output logic [1:0]   m_axis_tuser    // status
);

    arh_pkg::t_cmd cmd;
    arh_pkg::t_sts sts;

    logic [1:0]                 status;
    logic [arh_pkg::SEL_W-1:0]  bin_index;
    logic [arh_pkg::CNT_W-1:0]  bin_count;
    logic signed [32:0]         range_start;
    logic [arh_pkg::MAXB_W-1:0] used_bins;
    logic [arh_pkg::OVF_W-1:0]  oor_sum;
    logic                       limit_hit;

    assign o_cfg_ready = 1'b1;

    arh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    arh_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_func             (s_axis_tuser),
        .i_value            (s_axis_tdata[31:0]),
        .i_weight           (s_axis_tdata[47:32]),
        .i_bin_select       (s_axis_tdata[57:48]),
        .o_status           (status),
        .o_bin_index        (bin_index),
        .o_bin_count        (bin_count),
        .o_range_start      (range_start),
        .o_used_bins        (used_bins),
        .o_out_of_range_sum (oor_sum),
        .o_limit_hit        (limit_hit)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {1'b0, limit_hit, oor_sum, used_bins, range_start, bin_count,
                           bin_index};

endmodule

`default_nettype wire
